/* src/pcs_pkg.sv */
// ---------------------------------------------------------------------------
// pcs_pkg: shared types and constants for the pairwise cosine similarity block
// Transaction payloads, register indexes and the controller/datapath interface.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcs_pkg;

   localparam int DEF_MAX_ITEMS   = 64;
   localparam int DEF_MAX_USERS   = 256;
   localparam int DEF_RATING_BITS = 8;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_ROW  = 1'b1;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 9;
   localparam logic [CSR_INDEX_W-1:0] CSR_ITEM_COUNT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_USER_COUNT = 1'b1;

   localparam logic [6:0] ITEM_COUNT_RESET = 7'd64;
   localparam logic [8:0] USER_COUNT_RESET = 9'd256;

   // Q1.15 search: 16 result bits, upper bound of the magnitude is 1.0.
   localparam logic [3:0]  SEARCH_TOP_BIT = 4'd15;
   localparam logic [15:0] Q15_ONE       = 16'd32768;
   localparam logic [15:0] Q15_MAX       = 16'd32767;

   typedef struct packed {
      logic              kind;
      logic [5:0]        item_index;
      logic [7:0]        user_index;
      logic signed [7:0] rating_value;
   } req_type;

   typedef struct packed {
      logic [11:0]        pair_index;
      logic [5:0]         other_item;
      logic signed [15:0] similarity;
      logic               zero_norm;
      logic               last_of_row;
   } rsp_type;

   typedef struct packed {
      logic clr;
      logic load;
      logic row_start;
      logic pair_start;
      logic issue;
      logic prep;
      logic sq;
      logic mlo;
      logic mhi;
      logic cmp;
      logic emit;
      logic next_v;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic is_row;
      logic row_ok;
      logic issue_last;
      logic pipe_busy;
      logic zero_norm;
      logic last_bit;
      logic out_free;
      logic last_v;
   } sts_type;

endpackage

/* src/pcs_ram.sv */
// ---------------------------------------------------------------------------
// pcs_ram: generic RAM
// One write port and two read ports, read data registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

/* src/pcs_ctrl.sv */
// ---------------------------------------------------------------------------
// pcs_ctrl: sequencer of the similarity block
// Runs the clearing pass, loads, the per-pair accumulate and the Q1.15 search.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcs_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pcs_pkg::sts_type sts,
   output pcs_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_MAC, ST_DRAIN, ST_PREP,
      ST_SQ, ST_MLO, ST_MHI, ST_CMP, ST_EMIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr = 1'b1;
            if (sts.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (!sts.is_row) begin
                  cmd.load = 1'b1;
               end else if (sts.row_ok) begin
                  cmd.row_start  = 1'b1;
                  cmd.pair_start = 1'b1;
                  state_in       = ST_MAC;
               end
            end
         end
         ST_MAC: begin
            cmd.issue = 1'b1;
            if (sts.issue_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!sts.pipe_busy) state_in = ST_PREP;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = sts.zero_norm ? ST_EMIT : ST_SQ;
         end
         ST_SQ: begin
            cmd.sq   = 1'b1;
            state_in = ST_MLO;
         end
         ST_MLO: begin
            cmd.mlo  = 1'b1;
            state_in = ST_MHI;
         end
         ST_MHI: begin
            cmd.mhi  = 1'b1;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            cmd.cmp  = 1'b1;
            state_in = sts.last_bit ? ST_EMIT : ST_SQ;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.last_v) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.next_v     = 1'b1;
                  cmd.pair_start = 1'b1;
                  state_in       = ST_MAC;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* src/pcs_dp.sv */
// ---------------------------------------------------------------------------
// pcs_dp: datapath of the similarity block
// Registers, rating store, multiply-accumulate, Q1.15 search and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcs_dp #(
   parameter int MAX_ITEMS   = pcs_pkg::DEF_MAX_ITEMS,
   parameter int MAX_USERS   = pcs_pkg::DEF_MAX_USERS,
   parameter int RATING_BITS = pcs_pkg::DEF_RATING_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [pcs_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pcs_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  pcs_pkg::req_type                    req_data,
   input  pcs_pkg::cmd_type                    cmd,
   output pcs_pkg::sts_type                    sts,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output pcs_pkg::rsp_type                    rsp_data
);

   localparam int IW    = $clog2(MAX_ITEMS);
   localparam int UW    = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
   localparam int DEPTH = MAX_ITEMS * MAX_USERS;
   localparam int AW    = $clog2(DEPTH);
   localparam int RB    = RATING_BITS;
   localparam int SQ_W  = 2 * RB - 1;
   localparam int NW    = SQ_W + $clog2(MAX_USERS + 1);
   localparam int DW    = NW + 1;
   localparam int CW    = 32 + 2 * NW;

   // Configuration registers and their clamped values.
   logic [6:0] item_count_ff;
   logic [8:0] user_count_ff;
   logic [IW:0] items;
   logic [UW:0] users;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_count_ff <= pcs_pkg::ITEM_COUNT_RESET;
         user_count_ff <= pcs_pkg::USER_COUNT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            pcs_pkg::CSR_ITEM_COUNT: item_count_ff <= csr_wdata[6:0];
            pcs_pkg::CSR_USER_COUNT: user_count_ff <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (item_count_ff == 7'd0) begin
         items = (IW+1)'(1);
      end else if (32'(item_count_ff) > 32'(MAX_ITEMS)) begin
         items = (IW+1)'(MAX_ITEMS);
      end else begin
         items = (IW+1)'(item_count_ff);
      end
      if (user_count_ff == 9'd0) begin
         users = (UW+1)'(1);
      end else if (32'(user_count_ff) > 32'(MAX_USERS)) begin
         users = (UW+1)'(MAX_USERS);
      end else begin
         users = (UW+1)'(user_count_ff);
      end
   end

   // Store write side: clearing pass after reset, or one rating load.
   logic [AW-1:0]      clr_ff;
   logic [AW-1:0]      req_base;
   logic signed [15:0] rating_ext;
   logic               load_ok;
   logic               row_ok;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [RB-1:0]      wr_data;

   assign req_base   = AW'(req_data.item_index) * AW'(MAX_USERS);
   assign rating_ext = 16'(req_data.rating_value);
   assign row_ok     = 32'(req_data.item_index) < 32'(items);
   assign load_ok    = row_ok && (32'(req_data.user_index) < 32'(users));
   assign wr_en      = cmd.clr || (cmd.load && load_ok);
   assign wr_addr    = cmd.clr ? clr_ff : req_base + AW'(req_data.user_index);
   assign wr_data    = cmd.clr ? '0 : rating_ext[RB-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr) begin
         clr_ff <= clr_ff + AW'(1);
      end
   end

   // Row and pair bookkeeping.
   logic [IW-1:0] v_ff;
   logic [AW-1:0] u_base_ff, v_base_ff;
   logic [11:0]   pair_ff;
   logic [UW-1:0] i_ff;
   logic [15:0]   ux, pair_head, pair_tri;

   assign ux        = 16'(req_data.item_index);
   assign pair_head = ux * 16'(items);
   assign pair_tri  = (ux * (ux + 16'd1)) >> 1;

   always_ff @(posedge clock) begin
      if (cmd.row_start) begin
         v_ff      <= IW'(req_data.item_index);
         u_base_ff <= req_base;
         v_base_ff <= req_base;
         pair_ff   <= 12'(pair_head + ux - pair_tri);
      end else if (cmd.next_v) begin
         v_ff      <= v_ff + IW'(1);
         v_base_ff <= v_base_ff + AW'(MAX_USERS);
         pair_ff   <= pair_ff + 12'd1;
      end
      if (cmd.pair_start) begin
         i_ff <= '0;
      end else if (cmd.issue) begin
         i_ff <= i_ff + UW'(1);
      end
   end

   // Rating store, read one column of both rows per cycle.
   logic [RB-1:0] rd_a, rd_b;

   pcs_ram #(
      .WIDTH (RB),
      .DEPTH (DEPTH)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (u_base_ff + AW'(i_ff)),
      .rd_data_a (rd_a),
      .rd_addr_b (v_base_ff + AW'(i_ff)),
      .rd_data_b (rd_b)
   );

   // Multiply-accumulate pipeline: read, products, accumulate.
   logic                 v1_ff, v2_ff;
   logic signed [RB-1:0] sa, sb;
   logic signed [2*RB-1:0] ab_c, aa_c, bb_c;
   logic signed [2*RB-1:0] pab_ff;
   logic [SQ_W-1:0]      paa_ff, pbb_ff;
   logic signed [DW-1:0] dot_ff;
   logic [NW-1:0]        ud_ff, vd_ff;

   assign sa   = signed'(rd_a);
   assign sb   = signed'(rd_b);
   assign ab_c = sa * sb;
   assign aa_c = sa * sa;
   assign bb_c = sb * sb;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff;
      end
      pab_ff <= ab_c;
      paa_ff <= aa_c[SQ_W-1:0];
      pbb_ff <= bb_c[SQ_W-1:0];
      if (cmd.pair_start) begin
         dot_ff <= '0;
         ud_ff  <= '0;
         vd_ff  <= '0;
      end else if (v2_ff) begin
         dot_ff <= dot_ff + DW'(pab_ff);
         ud_ff  <= ud_ff + NW'(paa_ff);
         vd_ff  <= vd_ff + NW'(pbb_ff);
      end
   end

   // Bitwise search for the largest q with (2q-1)^2 * ud * vd <= (|dot| * 2^16)^2.
   logic [NW-1:0]   mag;
   logic [2*NW-1:0] prod_ff, magsq_ff;
   logic            neg_ff;
   logic [15:0]     lo_ff, cand, cand_ff, t_c;
   logic            cand_ok_ff;
   logic [3:0]      bit_ff;
   logic [31:0]     tsq_ff;
   logic [31+NW:0]  plo_ff, phi_ff;
   logic [CW-1:0]   full, rhs;

   assign mag  = NW'(dot_ff[DW-1] ? -dot_ff : dot_ff);
   assign cand = lo_ff | (16'd1 << bit_ff);
   assign t_c  = 16'({cand, 1'b0} - 17'd1);
   assign full = (CW'(phi_ff) << NW) + CW'(plo_ff);
   assign rhs  = CW'(magsq_ff) << 32;

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         prod_ff  <= ud_ff * vd_ff;
         magsq_ff <= mag * mag;
         neg_ff   <= dot_ff[DW-1];
         lo_ff    <= '0;
         bit_ff   <= pcs_pkg::SEARCH_TOP_BIT;
      end
      if (cmd.sq) begin
         cand_ff    <= cand;
         cand_ok_ff <= cand <= pcs_pkg::Q15_ONE;
         tsq_ff     <= t_c * t_c;
      end
      if (cmd.mlo) plo_ff <= tsq_ff * prod_ff[NW-1:0];
      if (cmd.mhi) phi_ff <= tsq_ff * prod_ff[2*NW-1:NW];
      if (cmd.cmp) begin
         if (cand_ok_ff && (full <= rhs)) lo_ff <= cand_ff;
         bit_ff <= bit_ff - 4'd1;
      end
   end

   // Result register.
   logic               zero_norm;
   logic               last_v;
   logic signed [15:0] sim;
   logic               rsp_valid_ff;
   pcs_pkg::rsp_type   rsp_data_ff;

   assign zero_norm = (ud_ff == '0) || (vd_ff == '0);
   assign last_v    = 32'(v_ff) == 32'(items) - 32'd1;

   always_comb begin
      if (zero_norm) begin
         sim = 16'sd0;
      end else if (neg_ff) begin
         sim = 16'(-{1'b0, lo_ff});
      end else if (lo_ff > pcs_pkg::Q15_MAX) begin
         sim = signed'(pcs_pkg::Q15_MAX);
      end else begin
         sim = signed'(lo_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         rsp_data_ff.pair_index  <= pair_ff;
         rsp_data_ff.other_item  <= 6'(v_ff);
         rsp_data_ff.similarity  <= sim;
         rsp_data_ff.zero_norm   <= zero_norm;
         rsp_data_ff.last_of_row <= last_v;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign sts.clr_last   = clr_ff == AW'(DEPTH - 1);
   assign sts.is_row     = req_data.kind == pcs_pkg::KIND_ROW;
   assign sts.row_ok     = row_ok;
   assign sts.issue_last = 32'(i_ff) == 32'(users) - 32'd1;
   assign sts.pipe_busy  = v1_ff || v2_ff;
   assign sts.zero_norm  = zero_norm;
   assign sts.last_bit   = bit_ff == 4'd0;
   assign sts.out_free   = !rsp_valid_ff || !rsp_stall;
   assign sts.last_v     = last_v;

endmodule

/* src/pairwise_cosine_similarity.sv */
// ---------------------------------------------------------------------------
// pairwise_cosine_similarity: cosine similarity of item rows
// Holds an item-by-user rating store; a row transaction yields one Q1.15
// similarity per pair (u, v) with v from u to the last item in use.
// ---------------------------------------------------------------------------
//  Channel   Direction  Handshake          Content
//  req_      in         req_valid/stall    load a rating, or compute one row
//  rsp_      out        rsp_valid/stall    one similarity result per pair
//  csr_      in         csr_wr_en          item_count, user_count
//
//  A load is written while the sequencer is idle. Per pair, a row runs the
//  multiply-accumulate over user_count columns (one column of both rows per
//  cycle), a drain, a setup step, the Q1.15 search unless a norm is zero, and
//  an emit step. After reset a clearing pass writes zeros to all MAX_ITEMS *
//  MAX_USERS entries (16384 at default) while req_stall stays high.
//  A stalled result holds the sequencer in its emit step.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pairwise_cosine_similarity #(
   parameter int MAX_ITEMS   = pcs_pkg::DEF_MAX_ITEMS,
   parameter int MAX_USERS   = pcs_pkg::DEF_MAX_USERS,
   parameter int RATING_BITS = pcs_pkg::DEF_RATING_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [pcs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pcs_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  pcs_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output pcs_pkg::rsp_type                rsp_data
);

   pcs_pkg::cmd_type cmd;
   pcs_pkg::sts_type sts;

   pcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   pcs_dp #(
      .MAX_ITEMS   (MAX_ITEMS),
      .MAX_USERS   (MAX_USERS),
      .RATING_BITS (RATING_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* src/pcs_checker.sv */
// ---------------------------------------------------------------------------
// pcs_checker: port checks for the similarity block
// Watches the top-level ports over time; bound to every instance.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcs_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input pcs_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input pcs_pkg::rsp_type rsp_data
);

   // The clearing pass keeps the input side closed right after reset.
   assert property (@(posedge clock) reset |=> req_stall)
      else $error("input open right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_norm |-> rsp_data.similarity == 16'sd0)
      else $error("zero norm with nonzero similarity");

   // A load never produces a result.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.kind == pcs_pkg::KIND_LOAD
      |=> !$rose(rsp_valid))
      else $error("result after a load");

endmodule

bind pairwise_cosine_similarity pcs_checker u_pcs_checker (.*);

/* sim/pairwise_cosine_similarity_tb.sv */
// ---------------------------------------------------------------------------
// pairwise_cosine_similarity_tb: self-checking bench for the row similarity block
// Loads ratings and requests row comparisons under several item and user
// counts. A local model of the rating store predicts every pair result, and
// a monitor compares each result transaction against the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pairwise_cosine_similarity_tb;
   import pcs_pkg::*;

   localparam int ITEMS_MAX = DEF_MAX_ITEMS;
   localparam int USERS_MAX = DEF_MAX_USERS;
   localparam int DRAIN_CYCLES = 400;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_ITEM_COUNT;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;

   req_type          pending_reqs[$];
   rsp_type          expected_pairs[$];
   logic signed [7:0] rating_copy[ITEMS_MAX][USERS_MAX];
   int unsigned      item_count_reg = ITEM_COUNT_RESET;
   int unsigned      user_count_reg = USER_COUNT_RESET;
   int unsigned      req_gap = 0;
   int unsigned      rsp_hold = 0;
   bit               no_idle = 1'b0;
   bit               failed = 1'b0;

   pairwise_cosine_similarity i_dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("** pairwise_cosine_similarity: FAILED **");
      $finish;
   end

   function automatic int unsigned active_items();
      if (item_count_reg == 0) return 1;
      if (item_count_reg > ITEMS_MAX) return ITEMS_MAX;
      return item_count_reg;
   endfunction

   function automatic int unsigned active_users();
      if (user_count_reg == 0) return 1;
      if (user_count_reg > USERS_MAX) return USERS_MAX;
      return user_count_reg;
   endfunction

   // Exact Q1.15 of dot / sqrt(ud * vd), rounded half away from zero.
   function automatic logic signed [15:0] q15_cosine(longint dot, longint ud, longint vd);
      logic [127:0] rhs;
      logic [127:0] prod;
      logic [127:0] odd;
      logic [63:0]  mag;
      int           lo;
      int           hi;
      int           mid;
      mag  = (dot < 0) ? -dot : dot;
      rhs  = (128'(mag) << 32) * 128'(mag);
      prod = 128'(ud) * 128'(vd);
      lo = 0;
      hi = 32768;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         odd = 128'(2 * mid - 1);
         if (prod * odd * odd <= rhs) lo = mid;
         else hi = mid - 1;
      end
      if (dot < 0) return 16'(-lo);
      return (lo > 32767) ? 16'sd32767 : 16'(lo);
   endfunction

   task automatic predict_similarities(req_type t);
      int unsigned n_items;
      int unsigned n_users;
      int unsigned u;
      longint      dot;
      longint      ud;
      longint      vd;
      longint      a;
      longint      b;
      rsp_type     r;
      n_items = active_items();
      n_users = active_users();
      u = t.item_index;
      if (t.kind == KIND_LOAD) begin
         if (u < n_items && t.user_index < n_users)
            rating_copy[u][t.user_index] = t.rating_value;
         return;
      end
      if (u >= n_items) return;
      for (int unsigned v = u; v < n_items; v++) begin
         dot = 0;
         ud = 0;
         vd = 0;
         for (int unsigned i = 0; i < n_users; i++) begin
            a = rating_copy[u][i];
            b = rating_copy[v][i];
            dot += a * b;
            ud += a * a;
            vd += b * b;
         end
         r.pair_index  = 12'(u * n_items + v - (u * (u + 1)) / 2);
         r.other_item  = 6'(v);
         r.zero_norm   = (ud == 0 || vd == 0);
         r.similarity  = r.zero_norm ? 16'sd0 : q15_cosine(dot, ud, vd);
         r.last_of_row = (v == n_items - 1);
         expected_pairs.push_back(r);
      end
   endtask

   // Request driver: one item per handshake, random gap before the next.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap <= 0;
      end else begin
         if (req_valid && !req_stall) predict_similarities(req_data);
         if (!(req_valid && req_stall)) begin
            if (req_gap != 0) begin
               req_valid <= 1'b0;
               req_gap <= req_gap - 1;
            end else if (pending_reqs.size() != 0) begin
               req_data <= pending_reqs.pop_front();
               req_valid <= 1'b1;
               req_gap <= no_idle ? 0 : $urandom_range(0, 8);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor and backpressure.
   always @(posedge clock) begin
      int unsigned n;
      rsp_type     e;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold <= 0;
      end else begin
         n = (rsp_hold != 0) ? rsp_hold - 1 : 0;
         if (rsp_valid && !rsp_stall) begin
            n = no_idle ? 0 : $urandom_range(0, 8);
            if (expected_pairs.size() == 0) begin
               $display("%0t: unexpected result %p", $time, rsp_data);
               failed = 1'b1;
            end else begin
               e = expected_pairs.pop_front();
               if (rsp_data.pair_index !== e.pair_index) begin
                  $display("%0t: pair_index exp %0d act %0d", $time, e.pair_index,
                           rsp_data.pair_index);
                  failed = 1'b1;
               end
               if (rsp_data.other_item !== e.other_item) begin
                  $display("%0t: other_item exp %0d act %0d", $time, e.other_item,
                           rsp_data.other_item);
                  failed = 1'b1;
               end
               if (rsp_data.similarity !== e.similarity) begin
                  $display("%0t: similarity exp %0d act %0d (pair %0d)", $time,
                           e.similarity, rsp_data.similarity, e.pair_index);
                  failed = 1'b1;
               end
               if (rsp_data.zero_norm !== e.zero_norm) begin
                  $display("%0t: zero_norm exp %0b act %0b", $time, e.zero_norm,
                           rsp_data.zero_norm);
                  failed = 1'b1;
               end
               if (rsp_data.last_of_row !== e.last_of_row) begin
                  $display("%0t: last_of_row exp %0b act %0b", $time, e.last_of_row,
                           rsp_data.last_of_row);
                  failed = 1'b1;
               end
            end
         end
         rsp_hold <= n;
         rsp_stall <= (n != 0);
      end
   end

   function automatic req_type make_req(logic kind, int item, int user, int rating);
      req_type t;
      t.kind = kind;
      t.item_index = 6'(item);
      t.user_index = 8'(user);
      t.rating_value = 8'(rating);
      return t;
   endfunction

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_pairs.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, int unsigned value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      if (idx == CSR_ITEM_COUNT) item_count_reg = value & 'h7F;
      else user_count_reg = value & 'h1FF;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Well-formed traffic is mostly in-range loads mixed with row requests;
   // some transactions use indices anywhere in the field range.
   task automatic queue_random(int count, int row_floor);
      int n_items;
      int n_users;
      int item;
      n_items = active_items();
      n_users = active_users();
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(0, 3) == 0) begin
            item = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
                                               : $urandom_range(row_floor, n_items - 1);
            pending_reqs.push_back(make_req(KIND_ROW, item, 0, 0));
         end else if ($urandom_range(0, 5) == 0) begin
            pending_reqs.push_back(make_req(KIND_LOAD, $urandom_range(0, 63),
                                            $urandom_range(0, 255), $urandom_range(0, 255)));
         end else begin
            pending_reqs.push_back(make_req(KIND_LOAD, $urandom_range(0, n_items - 1),
                                            $urandom_range(0, n_users - 1),
                                            $urandom_range(0, 255)));
         end
      end
   endtask

   initial begin
      for (int i = 0; i < ITEMS_MAX; i++)
         for (int j = 0; j < USERS_MAX; j++) rating_copy[i][j] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset counts: opposite extremes give exactly -1.0, equal rows saturate,
      // an empty row raises the zero-norm flag.
      pending_reqs.push_back(make_req(KIND_LOAD, 63, 255, -128));
      pending_reqs.push_back(make_req(KIND_LOAD, 62, 255, 127));
      pending_reqs.push_back(make_req(KIND_LOAD, 0, 0, 127));
      pending_reqs.push_back(make_req(KIND_LOAD, 60, 128, -1));
      pending_reqs.push_back(make_req(KIND_ROW, 63, 0, 0));
      pending_reqs.push_back(make_req(KIND_ROW, 62, 0, 0));
      pending_reqs.push_back(make_req(KIND_ROW, 61, 0, 0));
      pending_reqs.push_back(make_req(KIND_ROW, 60, 0, 0));
      wait_idle();

      // Zero counts act as one row and one column.
      write_reg(CSR_ITEM_COUNT, 0);
      write_reg(CSR_USER_COUNT, 0);
      pending_reqs.push_back(make_req(KIND_ROW, 0, 0, 0));
      pending_reqs.push_back(make_req(KIND_LOAD, 0, 1, 5));
      pending_reqs.push_back(make_req(KIND_LOAD, 1, 0, 5));
      pending_reqs.push_back(make_req(KIND_ROW, 1, 0, 0));
      pending_reqs.push_back(make_req(KIND_LOAD, 0, 0, 0));
      pending_reqs.push_back(make_req(KIND_ROW, 0, 0, 0));
      pending_reqs.push_back(make_req(KIND_ROW, 63, 0, 0));
      wait_idle();

      // Counts above the maximum clamp; rows are kept near the end to stay short.
      write_reg(CSR_ITEM_COUNT, 127);
      write_reg(CSR_USER_COUNT, 511);
      queue_random(20, 56);
      wait_idle();

      for (int p = 0; p < 4; p++) begin
         write_reg(CSR_ITEM_COUNT, $urandom_range(2, 8));
         write_reg(CSR_USER_COUNT, $urandom_range(1, 16));
         no_idle = (p == 1);
         queue_random(15, 0);
         wait_idle();
      end

      write_reg(CSR_ITEM_COUNT, 64);
      write_reg(CSR_USER_COUNT, 1);
      queue_random(10, 48);
      wait_idle();

      if (!failed) begin
         $display("** pairwise_cosine_similarity: PASSED **");
      end else begin
         $display("** pairwise_cosine_similarity: FAILED **");
      end
      $finish;
   end

endmodule

/* filelist.f */
src/pcs_pkg.sv
src/pcs_ram.sv
src/pcs_ctrl.sv
src/pcs_dp.sv
src/pairwise_cosine_similarity.sv
src/pcs_checker.sv
sim/pairwise_cosine_similarity_tb.sv
